@@ rtl/bpc_pkg.sv @@
// bpc_pkg: shared constants, codes and controller/datapath structs for the
// bigram pair counter. No dependencies.

package bpc_pkg;

  localparam int BUCKETS      = 4096;
  localparam int POOL_ENTRIES = 4096;

  localparam int BKT_W  = $clog2(BUCKETS);
  localparam int ENT_W  = $clog2(POOL_ENTRIES);
  localparam int LINK_W = ENT_W + 1;

  localparam int WORD_W = 20;
  localparam int KEY_W  = 32;
  localparam int SLOT_W = 12;
  localparam int CNT_W  = 31;
  localparam int ROT    = 5;

  localparam int IN_DATA_W  = 120;
  localparam int IN_USER_W  = 2;
  localparam int OUT_DATA_W = 88;
  localparam int OUT_USER_W = 3;

  localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

  typedef enum logic [1:0] {
    KIND_COUNT = 2'd0,
    KIND_READ  = 2'd1,
    KIND_CLEAR = 2'd2,
    KIND_NONE  = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ST_HIT      = 3'd0,
    ST_INSERT   = 3'd1,
    ST_INS_FULL = 3'd2,
    ST_DROP     = 3'd3,
    ST_READ     = 3'd4,
    ST_CLEARED  = 3'd5
  } status_t;

  typedef struct packed {
    logic [WORD_W-1:0] first;
    logic [WORD_W-1:0] second;
    logic [CNT_W-1:0]  count;
    logic [LINK_W-1:0] link;
  } entry_t;

  // controller -> datapath
  typedef struct packed {
    logic capture;   // latch item, launch head and slot reads
    logic head_chk;  // take bucket head, launch first entry read
    logic walk;      // step to next chain entry
    logic hit_wr;    // update matched entry
    logic swap_wr;   // write predecessor half of the swap
    logic insert;    // push new entry or drop
    logic read_res;  // form read-slot result
    logic clr_step;  // zero one bucket head
    logic clr_done;  // finish a clear transaction
    logic load_out;  // move result into output register
  } ctrl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    kind_t kind;
    logic  head_end;
    logic  hit;
    logic  link_end;
    logic  need_swap;
    logic  clr_last;
    logic  out_free;
  } dp_sts_t;

endpackage

@@ rtl/bpc_ctrl.sv @@
// bpc_ctrl: sequencing state machine for the bigram pair counter.
// Depends on bpc_pkg.

module bpc_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  bpc_pkg::dp_sts_t   sts,
  output bpc_pkg::ctrl_cmd_t cmd
);
  import bpc_pkg::*;

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_HEAD, S_ENTRY, S_SWAP, S_INSERT, S_READ, S_CLR, S_OUT
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      S_INIT: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.capture = 1'b1;
          case (sts.kind)
            KIND_COUNT: state_nxt = S_HEAD;
            KIND_READ:  state_nxt = S_READ;
            KIND_CLEAR: state_nxt = S_CLR;
            default:    state_nxt = S_IDLE;
          endcase
        end
      end
      S_HEAD: begin
        cmd.head_chk = 1'b1;
        state_nxt = sts.head_end ? S_INSERT : S_ENTRY;
      end
      S_ENTRY: begin
        if (sts.hit) begin
          cmd.hit_wr = 1'b1;
          state_nxt = sts.need_swap ? S_SWAP : S_OUT;
        end else begin
          cmd.walk = 1'b1;
          if (sts.link_end) state_nxt = S_INSERT;
        end
      end
      S_SWAP: begin
        cmd.swap_wr = 1'b1;
        state_nxt = S_OUT;
      end
      S_INSERT: begin
        cmd.insert = 1'b1;
        state_nxt = S_OUT;
      end
      S_READ: begin
        cmd.read_res = 1'b1;
        state_nxt = S_OUT;
      end
      S_CLR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) begin
          cmd.clr_done = 1'b1;
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_INIT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

@@ rtl/bpc_dpath.sv @@
// bpc_dpath: bucket head and entry pool memories, chain walk registers,
// result and output registers of the bigram pair counter. Depends on bpc_pkg.

module bpc_dpath (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic [bpc_pkg::IN_DATA_W-1:0]       in_tdata,
  input  logic [bpc_pkg::IN_USER_W-1:0]       in_tuser,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [bpc_pkg::OUT_DATA_W-1:0]      out_tdata,
  output logic [bpc_pkg::OUT_USER_W-1:0]      out_tuser,
  input  bpc_pkg::ctrl_cmd_t                  cmd,
  output bpc_pkg::dp_sts_t                    sts
);
  import bpc_pkg::*;

  // input unpack
  logic [WORD_W-1:0] in_w0, in_w1;
  logic [KEY_W-1:0]  in_k0, in_k1, mixed;
  logic [SLOT_W-1:0] in_slot;
  logic [BKT_W-1:0]  in_bkt;

  assign in_w0   = in_tdata[WORD_W-1:0];
  assign in_k0   = in_tdata[WORD_W+KEY_W-1:WORD_W];
  assign in_w1   = in_tdata[2*WORD_W+KEY_W-1:WORD_W+KEY_W];
  assign in_k1   = in_tdata[2*WORD_W+2*KEY_W-1:2*WORD_W+KEY_W];
  assign in_slot = in_tdata[2*WORD_W+2*KEY_W+SLOT_W-1:2*WORD_W+2*KEY_W];
  assign mixed   = in_k0 ^ {in_k1[KEY_W-ROT-1:0], in_k1[KEY_W-1:KEY_W-ROT]};
  assign in_bkt  = mixed[BKT_W-1:0];

  // memories
  logic [LINK_W-1:0] head_mem [BUCKETS];
  entry_t            ent_mem  [POOL_ENTRIES];
  logic [LINK_W-1:0] head_q;
  entry_t            ent_q;

  logic              hd_we;
  logic [BKT_W-1:0]  hd_wa;
  logic [LINK_W-1:0] hd_wd;
  logic              en_we, en_re;
  logic [ENT_W-1:0]  en_wa, en_ra;
  entry_t            en_wd;

  // item and walk registers
  logic [WORD_W-1:0] w0_r, w1_r;
  logic [BKT_W-1:0]  bkt_r;
  logic [SLOT_W-1:0] slot_r;
  logic [LINK_W-1:0] head_r, cur_r, prev_r;
  entry_t            prev_r_ent;
  logic [CNT_W-1:0]  hit_cnt_r;
  logic [LINK_W-1:0] used_r, used_nxt;
  logic [BKT_W-1:0]  clr_cnt_r;

  // result and output registers
  status_t           res_st_r;
  logic [CNT_W-1:0]  res_cnt_r;
  logic [WORD_W-1:0] res_a_r, res_b_r;
  logic              out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r;
  logic [OUT_USER_W-1:0] out_user_r;

  logic [CNT_W-1:0]  cnt_inc;
  logic [LINK_W-1:0] head_m1, link_m1, used_p1;
  logic              swap_now;

  function automatic logic [ENT_W-1:0] dec_idx(input logic [LINK_W-1:0] l);
    logic [LINK_W-1:0] d;
    d = l - LINK_W'(1);
    return d[ENT_W-1:0];
  endfunction

  function automatic logic [ENT_W-1:0] link_m1_cur();
    return dec_idx(cur_r);
  endfunction

  function automatic logic [ENT_W-1:0] prev_idx();
    return dec_idx(prev_r);
  endfunction

  assign cnt_inc  = (ent_q.count == COUNT_MAX) ? ent_q.count : ent_q.count + CNT_W'(1);
  assign head_m1  = head_q - LINK_W'(1);
  assign link_m1  = ent_q.link - LINK_W'(1);
  assign used_p1  = used_r + LINK_W'(1);
  assign swap_now = (prev_r != '0) && (cnt_inc > prev_r_ent.count);

  assign sts.kind      = kind_t'(in_tuser);
  assign sts.head_end  = (head_q == '0) || (head_q > used_r);
  assign sts.hit       = (ent_q.first == w0_r) && (ent_q.second == w1_r);
  assign sts.link_end  = (ent_q.link == '0) || (ent_q.link > used_r);
  assign sts.need_swap = swap_now;
  assign sts.clr_last  = (clr_cnt_r == BKT_W'(BUCKETS - 1));
  assign sts.out_free  = !out_valid_r || out_tready;

  // memory port muxing
  always_comb begin
    hd_we = 1'b0;
    hd_wa = bkt_r;
    hd_wd = '0;
    if (cmd.clr_step) begin
      hd_we = 1'b1;
      hd_wa = clr_cnt_r;
    end else if (cmd.insert && used_r < LINK_W'(POOL_ENTRIES)) begin
      hd_we = 1'b1;
      hd_wd = used_p1;
    end

    en_we = 1'b0;
    en_wa = used_r[ENT_W-1:0];
    en_wd = '{first: w0_r, second: w1_r, count: CNT_W'(1), link: head_r};
    if (cmd.hit_wr) begin
      en_we = 1'b1;
      en_wa = link_m1_cur();
      if (swap_now) begin
        en_wd = '{first: prev_r_ent.first, second: prev_r_ent.second,
                  count: prev_r_ent.count, link: ent_q.link};
      end else begin
        en_wd = '{first: w0_r, second: w1_r, count: cnt_inc, link: ent_q.link};
      end
    end else if (cmd.swap_wr) begin
      en_we = 1'b1;
      en_wa = prev_idx();
      en_wd = '{first: w0_r, second: w1_r, count: hit_cnt_r, link: cur_r};
    end else if (cmd.insert && used_r < LINK_W'(POOL_ENTRIES)) begin
      en_we = 1'b1;
    end

    en_re = 1'b0;
    en_ra = in_slot[ENT_W-1:0];
    if (cmd.capture) begin
      en_re = 1'b1;
    end else if (cmd.head_chk) begin
      en_re = 1'b1;
      en_ra = head_m1[ENT_W-1:0];
    end else if (cmd.walk) begin
      en_re = 1'b1;
      en_ra = link_m1[ENT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (hd_we) head_mem[hd_wa] <= hd_wd;
    if (cmd.capture) head_q <= head_mem[in_bkt];
    if (en_we) ent_mem[en_wa] <= en_wd;
    if (en_re) ent_q <= ent_mem[en_ra];
  end

  // used count
  always_comb begin
    used_nxt = used_r;
    if (cmd.clr_done) begin
      used_nxt = '0;
    end else if (cmd.insert && used_r < LINK_W'(POOL_ENTRIES)) begin
      used_nxt = used_p1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r      <= '0;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      used_r <= used_nxt;
      if (cmd.clr_step) clr_cnt_r <= clr_cnt_r + BKT_W'(1);
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // walk and result registers
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      w0_r   <= in_w0;
      w1_r   <= in_w1;
      bkt_r  <= in_bkt;
      slot_r <= in_slot;
    end
    if (cmd.head_chk) begin
      head_r <= head_q;
      cur_r  <= head_q;
      prev_r <= '0;
    end
    if (cmd.walk) begin
      prev_r     <= cur_r;
      prev_r_ent <= ent_q;
      cur_r      <= ent_q.link;
    end
    if (cmd.hit_wr) begin
      hit_cnt_r <= cnt_inc;
      res_st_r  <= ST_HIT;
      res_cnt_r <= cnt_inc;
      res_a_r   <= '0;
      res_b_r   <= '0;
    end
    if (cmd.insert) begin
      res_a_r <= '0;
      res_b_r <= '0;
      if (used_r < LINK_W'(POOL_ENTRIES)) begin
        res_st_r  <= (used_p1 == LINK_W'(POOL_ENTRIES)) ? ST_INS_FULL : ST_INSERT;
        res_cnt_r <= CNT_W'(1);
      end else begin
        res_st_r  <= ST_DROP;
        res_cnt_r <= '0;
      end
    end
    if (cmd.read_res) begin
      res_st_r <= ST_READ;
      if (LINK_W'(slot_r) < used_r) begin
        res_cnt_r <= ent_q.count;
        res_a_r   <= ent_q.first;
        res_b_r   <= ent_q.second;
      end else begin
        res_cnt_r <= '0;
        res_a_r   <= '0;
        res_b_r   <= '0;
      end
    end
    if (cmd.clr_done) begin
      res_st_r  <= ST_CLEARED;
      res_cnt_r <= '0;
      res_a_r   <= '0;
      res_b_r   <= '0;
    end
    if (cmd.load_out) begin
      out_user_r <= res_st_r;
      out_data_r <= {(OUT_DATA_W - CNT_W - 2*WORD_W - LINK_W)'(0),
                     used_r, res_b_r, res_a_r, res_cnt_r};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule

@@ rtl/bigram_pair_counter.sv @@
// bigram_pair_counter: top level, chained hash table of word-pair counts.
// Depends on bpc_pkg, bpc_ctrl, bpc_dpath.
//
//  channel  dir  handshake            payload
//  in_      in   in_tvalid/in_tready  tuser kind; tdata pair words, keys, slot
//  out_     out  out_tvalid/out_tready tuser status; tdata count, words, used
//
// A count takes the bucket head and walks the chain one entry at a time; a
// hit updates the entry, swapping it forward past a smaller predecessor, and
// a miss pushes a new entry. A clear zeroes one bucket head per cycle. The
// walk uses the single registered read port of the entry pool memory.
// Reset: synchronous, active low; a sweep then empties all bucket heads,
// and in_tready stays low until it ends.
// Stalls: the result sits in the output register; the next transaction is
// taken while it waits and holds in its last step only if it is still unread.

module bigram_pair_counter (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // [19:0] first_word, [51:20] first_key, [71:52] second_word,
  // [103:72] second_key, [115:104] slot, [119:116] zero
  input  logic [bpc_pkg::IN_DATA_W-1:0]    in_tdata,
  // [1:0] kind
  input  logic [bpc_pkg::IN_USER_W-1:0]    in_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // [30:0] pair_count, [50:31] out_first, [70:51] out_second,
  // [83:71] used_entries, [87:84] zero
  output logic [bpc_pkg::OUT_DATA_W-1:0]   out_tdata,
  // [2:0] status
  output logic [bpc_pkg::OUT_USER_W-1:0]   out_tuser
);
  import bpc_pkg::*;

  ctrl_cmd_t cmd;
  dp_sts_t   sts;

  bpc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  bpc_dpath u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cmd        (cmd),
    .sts        (sts)
  );

endmodule
